>>> src/ssrot_pkg.sv
// ----------------------------------------------------------------------------
// ssrot_pkg
// Shared types, constants and the digit decoder of the seven-segment scanner.
// ----------------------------------------------------------------------------
package ssrot_pkg;

    localparam int NUMBER_W   = 16;
    localparam int NIBBLES    = 4;
    localparam int SEG_W      = 7;
    localparam int EN_W       = 4;
    localparam int HOLD_W     = 16;
    localparam int ROT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int STORE_DEPTH_DEF = 16;
    localparam int DIGIT_COUNT_DEF = 4;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd5;
    localparam logic [ROT_W-1:0]  ROT_RESET  = 32'd1000;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COMMON_ANODE = 2'd0,
        REG_DIGIT_HOLD   = 2'd1,
        REG_ROTATE       = 2'd2
    } t_cfg_reg;

    // Per-transaction control that travels with the store read.
    typedef struct packed {
        logic       rejected;
        logic       nonempty;
        logic       bypass;
        logic       digit_on;
        logic [1:0] nib_sel;
    } t_disp_ctl;

    // Segments a..g in bits 0..6; codes above nine are blank.
    function automatic logic [SEG_W-1:0] seg_decode(input logic [3:0] code);
        logic [SEG_W-1:0] seg;
        case (code)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = '0;
        endcase
        return seg;
    endfunction

endpackage

>>> src/ssrot_in_if.sv
// ----------------------------------------------------------------------------
// ssrot_in_if
// Input channel: action code and BCD number with valid/ready.
// ----------------------------------------------------------------------------
interface ssrot_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] number_bcd;

    modport source (output valid, output action, output number_bcd, input ready);
    modport sink   (input valid, input action, input number_bcd, output ready);
endinterface

>>> src/ssrot_out_if.sv
// ----------------------------------------------------------------------------
// ssrot_out_if
// Result channel: display lines, stored count and reject flag with valid/ready.
// ----------------------------------------------------------------------------
interface ssrot_out_if #(
    parameter int CNT_W = 5
);
    logic             valid;
    logic             ready;
    logic [3:0]       digit_enable;
    logic [6:0]       segment_lines;
    logic [CNT_W-1:0] stored_count;
    logic             add_rejected;

    modport source (output valid, output digit_enable, output segment_lines,
                    output stored_count, output add_rejected, input ready);
    modport sink   (input valid, input digit_enable, input segment_lines,
                    input stored_count, input add_rejected, output ready);
endinterface

>>> src/seven_segment_scan_with_rotation.sv
// Pipeline: an accepted transaction passes the store read stage, then the
//   output register, which holds its result while the receiver stalls.
// Throughput: one transaction per cycle unless the output stalls; the store is
//   one RAM with one write and one read port, and an add to the entry being read is forwarded.
// Reset: counters, fill count and registers return to their defaults at once;
//   store contents are not cleared, entries at or above the fill count are never shown.
// ----------------------------------------------------------------------------
// seven_segment_scan_with_rotation
// Multiplexed seven-segment driver that rotates through a store of BCD numbers.
// ----------------------------------------------------------------------------
module seven_segment_scan_with_rotation #(
    parameter int STORE_DEPTH = ssrot_pkg::STORE_DEPTH_DEF,
    parameter int DIGIT_COUNT = ssrot_pkg::DIGIT_COUNT_DEF,
    parameter int CNT_W       = $clog2(STORE_DEPTH + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ssrot_in_if.sink                        i_item,
    ssrot_out_if.source                     o_result,
    input  logic                            i_cfg_we,
    input  logic [ssrot_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ssrot_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ssrot_pkg::*;

    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic              r_common_anode;
    logic [HOLD_W-1:0] r_hold_ticks;
    logic [ROT_W-1:0]  r_rotate_ticks;

    logic              in_ready;
    logic              accept;
    logic              we;
    logic              re;
    logic [IDX_W-1:0]  waddr;
    logic [IDX_W-1:0]  raddr;
    logic [NUMBER_W-1:0] rdata;
    logic [CNT_W-1:0]  count;
    t_disp_ctl         ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_common_anode <= 1'b0;
            r_hold_ticks   <= HOLD_RESET;
            r_rotate_ticks <= ROT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_COMMON_ANODE: r_common_anode <= i_cfg_data[0];
                REG_DIGIT_HOLD:   r_hold_ticks   <= i_cfg_data[HOLD_W-1:0];
                REG_ROTATE:       r_rotate_ticks <= i_cfg_data[ROT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign accept       = i_item.valid && in_ready;
    assign i_item.ready = in_ready;

    ssrot_ctrl #(
        .STORE_DEPTH (STORE_DEPTH),
        .DIGIT_COUNT (DIGIT_COUNT),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_action       (i_item.action),
        .i_hold_ticks   (r_hold_ticks),
        .i_rotate_ticks (r_rotate_ticks),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_re           (re),
        .o_raddr        (raddr),
        .o_count        (count),
        .o_ctl          (ctl)
    );

    ssrot_ram #(
        .WIDTH (NUMBER_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_item.number_bcd),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ssrot_disp #(
        .CNT_W (CNT_W)
    ) u_disp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_ctl           (ctl),
        .i_count         (count),
        .i_wdata         (i_item.number_bcd),
        .i_rdata         (rdata),
        .i_common_anode  (r_common_anode),
        .i_out_ready     (o_result.ready),
        .o_in_ready      (in_ready),
        .o_valid         (o_result.valid),
        .o_digit_enable  (o_result.digit_enable),
        .o_segment_lines (o_result.segment_lines),
        .o_stored_count  (o_result.stored_count),
        .o_add_rejected  (o_result.add_rejected)
    );
endmodule

>>> src/ssrot_ram.sv
// ----------------------------------------------------------------------------
// ssrot_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssrot_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/ssrot_ctrl.sv
// ----------------------------------------------------------------------------
// ssrot_ctrl
// Scan and rotation state: counters, store fill and store access per action.
// ----------------------------------------------------------------------------
module ssrot_ctrl #(
    parameter int STORE_DEPTH = 16,
    parameter int DIGIT_COUNT = 4,
    parameter int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1,
    parameter int CNT_W       = $clog2(STORE_DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [1:0]                        i_action,
    input  logic [ssrot_pkg::HOLD_W-1:0]      i_hold_ticks,
    input  logic [ssrot_pkg::ROT_W-1:0]       i_rotate_ticks,
    output logic                              o_we,
    output logic [IDX_W-1:0]                  o_waddr,
    output logic                              o_re,
    output logic [IDX_W-1:0]                  o_raddr,
    output logic [CNT_W-1:0]                  o_count,
    output ssrot_pkg::t_disp_ctl              o_ctl
);
    import ssrot_pkg::*;

    localparam int DIG_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_shown, n_shown;
    logic [ROT_W-1:0]  r_rot, n_rot;
    logic [HOLD_W-1:0] r_hold, n_hold;
    logic [DIG_W-1:0]  r_digit, n_digit;

    logic [HOLD_W-1:0] hold_inc;
    logic              full;
    logic              rejected;
    logic              add_ok;
    logic [7:0]        digit_ext;

    always_comb begin
        n_count  = r_count;
        n_shown  = r_shown;
        n_rot    = r_rot;
        n_hold   = r_hold;
        n_digit  = r_digit;
        rejected = 1'b0;
        add_ok   = 1'b0;
        full     = (r_count == CNT_W'(STORE_DEPTH));
        hold_inc = r_hold + 1'b1;

        case (t_action'(i_action))
            ACT_TICK: begin
                if (hold_inc >= i_hold_ticks || hold_inc == '0) begin
                    n_hold  = '0;
                    n_digit = (r_digit == DIG_W'(DIGIT_COUNT - 1)) ? '0 : r_digit + 1'b1;
                end else begin
                    n_hold = hold_inc;
                end
                if ({1'b0, r_rot} + 33'd1 >= {1'b0, i_rotate_ticks}) begin
                    n_rot = '0;
                    if (r_count == '0 || CNT_W'(r_shown) + 1'b1 == r_count) begin
                        n_shown = '0;
                    end else begin
                        n_shown = r_shown + 1'b1;
                    end
                end else begin
                    n_rot = r_rot + 1'b1;
                end
            end
            ACT_ADD: begin
                if (full) begin
                    rejected = 1'b1;
                end else begin
                    add_ok  = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            ACT_CLEAR: begin
                n_count = '0;
                n_shown = '0;
                n_rot   = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_shown <= '0;
            r_rot   <= '0;
            r_hold  <= '0;
            r_digit <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
            r_shown <= n_shown;
            r_rot   <= n_rot;
            r_hold  <= n_hold;
            r_digit <= n_digit;
        end
    end

    assign digit_ext = {{(8 - DIG_W){1'b0}}, n_digit};

    assign o_we    = i_accept && add_ok;
    assign o_waddr = r_count[IDX_W-1:0];
    assign o_re    = i_accept;
    assign o_raddr = n_shown;
    assign o_count = n_count;

    // The add may land on the entry being read; the RAM returns old data then.
    assign o_ctl.rejected = rejected;
    assign o_ctl.nonempty = (n_count != '0);
    assign o_ctl.bypass   = add_ok && (r_count[IDX_W-1:0] == n_shown);
    assign o_ctl.digit_on = (digit_ext < 8'd4);
    assign o_ctl.nib_sel  = digit_ext[1:0];
endmodule

>>> src/ssrot_disp.sv
// ----------------------------------------------------------------------------
// ssrot_disp
// Two-stage result path: store read stage, then decoded output register.
// ----------------------------------------------------------------------------
module ssrot_disp #(
    parameter int CNT_W = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  ssrot_pkg::t_disp_ctl          i_ctl,
    input  logic [CNT_W-1:0]              i_count,
    input  logic [ssrot_pkg::NUMBER_W-1:0] i_wdata,
    input  logic [ssrot_pkg::NUMBER_W-1:0] i_rdata,
    input  logic                          i_common_anode,
    input  logic                          i_out_ready,
    output logic                          o_in_ready,
    output logic                          o_valid,
    output logic [ssrot_pkg::EN_W-1:0]    o_digit_enable,
    output logic [ssrot_pkg::SEG_W-1:0]   o_segment_lines,
    output logic [CNT_W-1:0]              o_stored_count,
    output logic                          o_add_rejected
);
    import ssrot_pkg::*;

    logic                r_a_valid;
    t_disp_ctl           r_a_ctl;
    logic [CNT_W-1:0]    r_a_count;
    logic [NUMBER_W-1:0] r_a_byp;

    logic                r_b_valid;
    logic [EN_W-1:0]     r_b_en;
    logic [SEG_W-1:0]    r_b_seg;
    logic [CNT_W-1:0]    r_b_count;
    logic                r_b_rej;

    logic                b_load;
    logic [NUMBER_W-1:0] word;
    logic [3:0]          code;
    logic [EN_W-1:0]     n_en;
    logic [SEG_W-1:0]    n_seg;

    assign b_load     = r_a_valid && (!r_b_valid || i_out_ready);
    assign o_in_ready = !r_a_valid || b_load;

    always_comb begin
        word  = r_a_ctl.bypass ? r_a_byp : i_rdata;
        code  = word[4*r_a_ctl.nib_sel +: 4];
        n_en  = r_a_ctl.digit_on ? (EN_W'(1) << r_a_ctl.nib_sel) : '0;
        n_seg = (r_a_ctl.nonempty && r_a_ctl.digit_on) ? seg_decode(code) : '0;
        if (i_common_anode) begin
            n_en  = ~n_en;
            n_seg = ~n_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_a_valid <= 1'b1;
            end else if (b_load) begin
                r_a_valid <= 1'b0;
            end
            if (b_load) begin
                r_b_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_ctl   <= i_ctl;
            r_a_count <= i_count;
            r_a_byp   <= i_wdata;
        end
        if (b_load) begin
            r_b_en    <= n_en;
            r_b_seg   <= n_seg;
            r_b_count <= r_a_count;
            r_b_rej   <= r_a_ctl.rejected;
        end
    end

    assign o_valid         = r_b_valid;
    assign o_digit_enable  = r_b_en;
    assign o_segment_lines = r_b_seg;
    assign o_stored_count  = r_b_count;
    assign o_add_rejected  = r_b_rej;
endmodule

>>> verif/seven_segment_scan_with_rotation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_with_rotation_checker
// Watches the item, result and register ports of the display scanner, keeps a
// cycle-free model of the scan and rotation state, and compares each result
// transaction field by field against the oldest predicted display.
// ----------------------------------------------------------------------------
module seven_segment_scan_with_rotation_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ssrot_in_if                              i_item,
    ssrot_out_if                             i_result,
    input  logic                             i_cfg_we,
    input  logic [ssrot_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssrot_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    import ssrot_pkg::*;

    typedef struct packed {
        logic [EN_W-1:0]  enable;
        logic [SEG_W-1:0] segments;
        logic [4:0]       count;
        logic             rejected;
    } t_display;

    localparam logic [SEG_W-1:0] SEGMENT_FONT [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    logic [NUMBER_W-1:0] number_bank [STORE_DEPTH_DEF];
    logic [4:0]          fill_level;
    logic [3:0]          showing;
    logic [ROT_W-1:0]    rotate_elapsed;
    logic [HOLD_W-1:0]   hold_elapsed;
    logic [1:0]          lit_digit;

    logic                anode_mode;
    logic [HOLD_W-1:0]   hold_period;
    logic [ROT_W-1:0]    rotate_period;

    t_display expected_display_q [$];
    int       mismatch_count = 0;
    int       outstanding    = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = outstanding;

    function automatic t_display advance_display(input logic [1:0] act,
                                                 input logic [NUMBER_W-1:0] num);
        t_display   d;
        logic [3:0] code;
        logic [32:0] rotate_next;
        d = '0;
        if (act == ACT_TICK) begin
            hold_elapsed = hold_elapsed + 16'd1;
            // A zero period acts like one: move on every tick.
            if (hold_elapsed >= hold_period || hold_elapsed == '0) begin
                hold_elapsed = '0;
                lit_digit    = lit_digit + 2'd1;
            end
            rotate_next = {1'b0, rotate_elapsed} + 33'd1;
            if (rotate_next >= {1'b0, rotate_period}) begin
                rotate_elapsed = '0;
                showing = (fill_level != '0) ?
                          4'((int'(showing) + 1) % int'(fill_level)) : '0;
            end else begin
                rotate_elapsed = rotate_next[ROT_W-1:0];
            end
        end else if (act == ACT_ADD) begin
            if (fill_level < STORE_DEPTH_DEF) begin
                number_bank[fill_level[3:0]] = num;
                fill_level = fill_level + 5'd1;
            end else begin
                d.rejected = 1'b1;
            end
        end else if (act == ACT_CLEAR) begin
            fill_level     = '0;
            showing        = '0;
            rotate_elapsed = '0;
        end
        d.enable = 4'b0001 << lit_digit;
        if (fill_level != '0 && showing < fill_level) begin
            code = number_bank[showing][lit_digit*4 +: 4];
            if (code < 4'd10) begin
                d.segments = SEGMENT_FONT[code];
            end
        end
        if (anode_mode) begin
            d.enable   = ~d.enable;
            d.segments = ~d.segments;
        end
        d.count = fill_level;
        return d;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_display want;
        if (!i_rst_n) begin
            fill_level     = '0;
            showing        = '0;
            rotate_elapsed = '0;
            hold_elapsed   = '0;
            lit_digit      = '0;
            anode_mode     = 1'b0;
            hold_period    = HOLD_RESET;
            rotate_period  = ROT_RESET;
            expected_display_q.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                if (expected_display_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual %0h %0h %0d %0b",
                             $time, i_result.digit_enable, i_result.segment_lines,
                             i_result.stored_count, i_result.add_rejected);
                end else begin
                    want = expected_display_q.pop_front();
                    check_field("digit_enable", 32'(want.enable),
                                32'(i_result.digit_enable));
                    check_field("segment_lines", 32'(want.segments),
                                32'(i_result.segment_lines));
                    check_field("stored_count", 32'(want.count),
                                32'(i_result.stored_count));
                    check_field("add_rejected", 32'(want.rejected),
                                32'(i_result.add_rejected));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_COMMON_ANODE: anode_mode    = i_cfg_data[0];
                    REG_DIGIT_HOLD:   hold_period   = i_cfg_data[HOLD_W-1:0];
                    REG_ROTATE:       rotate_period = i_cfg_data[ROT_W-1:0];
                    default: ;
                endcase
            end
            if (i_item.valid && i_item.ready) begin
                expected_display_q.push_back(advance_display(i_item.action,
                                                             i_item.number_bcd));
            end
        end
        outstanding = expected_display_q.size();
    end

endmodule

>>> verif/seven_segment_scan_with_rotation_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_with_rotation_test
// Drives ticks, adds, clears and stray action codes into the display scanner
// under several register settings, with bursty input, a stalling receiver and
// one long receiver hold-off; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module seven_segment_scan_with_rotation_test;
    import ssrot_pkg::*;

    localparam logic [1:0] ACT_UNDEFINED = 2'd3;
    localparam int         LONG_HOLD_OFF = 80;
    localparam int         HOLD_OFF_AT   = 400;
    localparam int         PHASE_ITEMS   = 125;
    localparam int         PHASES        = 6;

    localparam logic        ANODE_PLAN  [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    localparam logic [31:0] HOLD_PLAN   [PHASES] = '{0, 3, 65535, 2, 1, 4};
    localparam logic [31:0] ROTATE_PLAN [PHASES] = '{0, 7, 32'hFFFF_FFFF, 1, 5, 12};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    items_sent = 0;
    bit                    hold_off_done = 1'b0;

    ssrot_in_if                item_if ();
    ssrot_out_if #(.CNT_W(5))  result_if ();

    seven_segment_scan_with_rotation u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_item      (item_if),
        .o_result    (result_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    seven_segment_scan_with_rotation_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_item       (item_if),
        .i_result     (result_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Ready is sampled at the falling edge, where everything driven at the
    // rising edge has settled.
    task automatic send_item(input logic [1:0] act, input logic [NUMBER_W-1:0] num);
        logic took;
        item_if.valid      <= 1'b1;
        item_if.action     <= act;
        item_if.number_bcd <= num;
        do begin
            @(negedge clk);
            took = item_if.ready;
            @(posedge clk);
        end while (!took);
        items_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            item_if.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        item_if.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic set_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic anode, input logic [31:0] hold,
                                 input logic [31:0] rotate);
        set_reg(REG_COMMON_ANODE, {31'd0, anode});
        set_reg(REG_DIGIT_HOLD, hold);
        set_reg(REG_ROTATE, rotate);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random_phase(input int target);
        int                  useful;
        int                  burst_left;
        int                  pick;
        logic [1:0]          act;
        logic [NUMBER_W-1:0] num;
        useful     = 0;
        burst_left = $urandom_range(1, 24);
        while (useful < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 58)      act = ACT_TICK;
            else if (pick < 84) act = ACT_ADD;
            else if (pick < 90) act = ACT_CLEAR;
            else                act = ACT_UNDEFINED;
            if ($urandom_range(0, 3) == 0) begin
                num = NUMBER_W'($urandom);
            end else begin
                for (int k = 0; k < NIBBLES; k++) begin
                    num[k*4 +: 4] = 4'($urandom_range(0, 9));
                end
            end
            send_item(act, num);
            useful++;
            burst_left--;
            if (burst_left == 0) begin
                pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    // Receiver: rotate through stall patterns, plus one long hold-off while
    // the sender keeps offering.
    initial begin : receiver
        int cyc;
        int hold_left;
        cyc       = 0;
        hold_left = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            cyc++;
            if (hold_left == 0 && !hold_off_done && items_sent >= HOLD_OFF_AT) begin
                hold_left     = LONG_HOLD_OFF;
                hold_off_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else begin
                case ((cyc / 200) % 4)
                    0:       result_if.ready <= 1'b1;
                    1:       result_if.ready <= 1'($urandom_range(0, 1));
                    2:       result_if.ready <= ($urandom_range(0, 3) == 0);
                    default: result_if.ready <= ((cyc % 5) < 3);
                endcase
            end
        end
    end

    initial begin
        rst_n              <= 1'b0;
        item_if.valid      <= 1'b0;
        item_if.action     <= ACT_TICK;
        item_if.number_bcd <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_COMMON_ANODE;
        cfg_data           <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty store under reset settings: blank display, stray code, clear.
        send_item(ACT_TICK, 16'h0000);
        send_item(ACT_UNDEFINED, 16'hFFFF);
        send_item(ACT_CLEAR, 16'h0000);
        wait_drained();

        // Move digit and rotation on every tick; fill the store past full.
        load_settings(1'b0, 32'd1, 32'd1);
        send_item(ACT_ADD, 16'h0000);
        send_item(ACT_ADD, 16'hFFFF);
        for (int i = 2; i < STORE_DEPTH_DEF; i++) begin
            send_item(ACT_ADD, {4'(i % 10), 4'((i + 1) % 10), 4'((i + 2) % 10),
                                4'((i + 3) % 10)});
        end
        send_item(ACT_ADD, 16'h4321);
        repeat (4) send_item(ACT_TICK, 16'h0000);
        send_item(ACT_CLEAR, 16'h0000);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            load_settings(ANODE_PLAN[p], HOLD_PLAN[p], ROTATE_PLAN[p]);
            run_random_phase(PHASE_ITEMS);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("seven_segment_scan_with_rotation verification clean");
        end else begin
            $display("seven_segment_scan_with_rotation verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("seven_segment_scan_with_rotation verification failed");
        $finish;
    end

endmodule

>>> files.f
src/ssrot_pkg.sv
src/ssrot_in_if.sv
src/ssrot_out_if.sv
src/ssrot_ram.sv
src/ssrot_ctrl.sv
src/ssrot_disp.sv
src/seven_segment_scan_with_rotation.sv
verif/seven_segment_scan_with_rotation_checker.sv
verif/seven_segment_scan_with_rotation_test.sv
